FILE: src/md5_pkg.sv
// md5_pkg: types, constants and round tables for the md5 message digest block
// no dependencies
`timescale 1ns / 1ps
package md5_pkg;
    typedef struct packed {
        logic       has_byte;
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_EMIT
    } t_state;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [7:0]  PAD_MARK = 8'h80;

    function automatic logic [31:0] round_const(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [3:0] i);
        logic [4:0] s;
        case (i)
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction
endpackage

FILE: src/md5_round.sv
// md5_round: the shared md5 round unit, one round per call
// depends on md5_pkg
`timescale 1ns / 1ps
module md5_round
    import md5_pkg::*;
(
    input  logic [5:0]  i_r,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    input  logic [31:0] i_d,
    input  logic [31:0] i_m,
    output logic [31:0] o_b
);
    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] dbl;
    logic [4:0]  s;

    always_comb begin
        case (i_r[5:4])
            2'd0: f = (i_b & i_c) | (~i_b & i_d);
            2'd1: f = (i_d & i_b) | (~i_d & i_c);
            2'd2: f = i_b ^ i_c ^ i_d;
            default: f = i_c ^ (i_b | ~i_d);
        endcase
        sum = i_a + f + round_const(i_r) + i_m;
        s = rot_amount({i_r[5:4], i_r[1:0]});
        dbl = {sum, sum} << s;
        o_b = i_b + dbl[63:32];
    end
endmodule

FILE: src/md5_message_digest.sv
// md5_message_digest: top level, byte gathering, padding and round sequencer
// depends on md5_pkg and md5_round
//
// input channel: one item per byte (has_byte, data_byte, end_of_message).
// an idle item (no byte, no end) is taken and ignored.
// a byte that does not fill a block leaves the input open; the 64th byte of a
// block starts the rounds and then the chaining add, during which
// o_in_stall is high.
// an end item runs padding, one byte position per cycle, then one or two
// final compressions, each of rounds and a chaining add, then four digest items, word 0
// (A) to word 3 (D), last_word on D. the input is stalled until the last
// digest item is taken. a stalled output item holds.
// rate is set by the single shared round unit: one round per cycle.
// reset (synchronous, active low) restores the initial chaining value,
// clears the byte and length counters and returns to idle.
`timescale 1ns / 1ps
module md5_message_digest
    import md5_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);
    t_state      r_state, n_state;
    logic [31:0] r_cv [4];
    logic [31:0] r_w  [16];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [5:0]  r_pos;
    logic [63:0] r_len;
    logic [5:0]  r_rnd;
    logic        r_fin;
    logic        r_mrk;
    logic        r_last_blk;
    logic [1:0]  r_k;
    logic [3:0]  g;
    logic [31:0] new_b;
    logic        acc;
    logic [7:0]  pbyte;
    logic        pwrite;
    logic        len_wr;

    md5_round u_round (
        .i_r(r_rnd), .i_a(r_a), .i_b(r_b), .i_c(r_c), .i_d(r_d),
        .i_m(r_w[g]), .o_b(new_b)
    );

    always_comb begin
        case (r_rnd[5:4])
            2'd0: g = r_rnd[3:0];
            2'd1: g = 4'(5 * r_rnd[3:0] + 1);
            2'd2: g = 4'(3 * r_rnd[3:0] + 5);
            default: g = 4'(7 * r_rnd[3:0]);
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign acc         = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == ST_EMIT);
    assign o_out_item  = '{digest_word: r_cv[r_k], word_index: r_k,
                           last_word: (r_k == 2'd3)};
    assign len_wr      = (r_state == ST_PAD) && (r_pos == 6'd56) && r_mrk;

    always_comb begin
        pwrite = 1'b0;
        pbyte  = 8'h0;
        if (acc && i_in_item.has_byte) begin
            pwrite = 1'b1;
            pbyte  = i_in_item.data_byte;
        end else if (r_state == ST_PAD) begin
            pwrite = 1'b1;
            pbyte  = r_mrk ? 8'h0 : PAD_MARK;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (i_in_item.has_byte && r_pos == 6'd63) n_state = ST_ROUND;
                    else if (i_in_item.end_of_message) n_state = ST_PAD;
                end
            end
            ST_ROUND: if (r_rnd == 6'd63) n_state = ST_ADD;
            ST_ADD: begin
                if (r_last_blk) n_state = ST_EMIT;
                else n_state = r_fin ? ST_PAD : ST_IDLE;
            end
            ST_PAD: begin
                if (len_wr) n_state = ST_ROUND;
                else if (r_pos == 6'd63) n_state = ST_ROUND;
            end
            ST_EMIT: if (!i_out_stall && r_k == 2'd3) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cv[0] <= IV0; r_cv[1] <= IV1; r_cv[2] <= IV2; r_cv[3] <= IV3;
            r_pos <= '0; r_len <= '0; r_rnd <= '0; r_fin <= 1'b0; r_k <= '0;
            r_mrk <= 1'b0;
        end else begin
            r_state <= n_state;
            if (acc && i_in_item.has_byte) r_len <= r_len + 64'd8;
            if (acc && i_in_item.end_of_message) r_fin <= 1'b1;
            if (len_wr) begin
                r_w[14] <= r_len[31:0];
                r_w[15] <= r_len[63:32];
                r_pos <= '0;
                r_fin <= 1'b0;
                r_mrk <= 1'b0;
                r_k   <= 2'd3;
            end else if (pwrite) begin
                if (r_pos[1:0] == 2'd0) r_w[r_pos[5:2]] <= {24'h0, pbyte};
                else r_w[r_pos[5:2]][r_pos[1:0]*8 +: 8] <= pbyte;
                r_pos <= r_pos + 6'd1;
                if (r_state == ST_PAD) r_mrk <= 1'b1;
            end
            if (n_state == ST_ROUND && r_state != ST_ROUND) begin
                r_a <= r_cv[0]; r_b <= r_cv[1]; r_c <= r_cv[2]; r_d <= r_cv[3];
                r_rnd <= '0;
            end else if (r_state == ST_ROUND) begin
                r_a <= r_d; r_d <= r_c; r_c <= r_b; r_b <= new_b;
                r_rnd <= r_rnd + 6'd1;
            end
            if (r_state == ST_ADD) begin
                r_cv[0] <= r_cv[0] + r_a; r_cv[1] <= r_cv[1] + r_b;
                r_cv[2] <= r_cv[2] + r_c; r_cv[3] <= r_cv[3] + r_d;
                if (r_k == 2'd3 && !r_fin) r_k <= 2'd0;
            end
            if (r_state == ST_EMIT && !i_out_stall) begin
                r_k <= r_k + 2'd1;
                if (r_k == 2'd3) begin
                    r_cv[0] <= IV0; r_cv[1] <= IV1; r_cv[2] <= IV2; r_cv[3] <= IV3;
                    r_len <= '0;
                end
            end
        end
    end

    // after the final block's add, go to emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_last_blk <= 1'b0;
        else if (len_wr) r_last_blk <= 1'b1;
        else if (r_state == ST_ADD) r_last_blk <= 1'b0;
    end

`ifndef SYNTHESIS
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> o_in_stall) else $error("input open during rounds");
    a_rnd_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_rnd != 6'd63) |=> (r_rnd == $past(r_rnd) + 6'd1))
        else $error("round counter skipped");
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(r_k)) else $error("digest word moved");
`endif
endmodule
